FILE: rtl/imu_complementary_attitude_filter_core_defines.svh
// ----------------------------------------------------------------------------
// Attitude filter assertion macros
// Concurrent assertion wrappers, clocked on clk; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef IMU_COMPLEMENTARY_ATTITUDE_FILTER_CORE_DEFINES_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_FILTER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// property checked outside reset
`define ICAF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked at every edge, reset included
`define ICAF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ICAF_ASSERT(name, prop, msg)
`define ICAF_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

FILE: rtl/icaf_pkg.sv
// ----------------------------------------------------------------------------
// Attitude filter package
// Word types, fixed-point constants and small arithmetic helpers.
// ----------------------------------------------------------------------------
package icaf_pkg;

  // datapath widths: multiplier operand, product, Q30 angle value
  localparam int MW = 34;
  localparam int PW = 2 * MW;
  localparam int VW = 36;

  typedef struct packed {
    logic signed [15:0] accel_raw_x;
    logic signed [15:0] accel_raw_y;
    logic signed [15:0] accel_raw_z;
    logic signed [15:0] gyro_raw_x;
    logic signed [15:0] gyro_raw_y;
    logic signed [15:0] gyro_raw_z;
    logic        [15:0] dt_us;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } out_word_t;

  localparam logic [15:0]          ALPHA_RESET = 16'd64225;
  localparam logic signed [VW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [VW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [MW-1:0] INV_GAIN    = 34'sd652032874;
  localparam logic signed [MW-1:0] STEP_MUL    = 34'sd614420649;
  localparam logic signed [MW-1:0] RATE_MUL    = 34'sd35764;
  localparam logic signed [MW-1:0] ACC_MUL     = 34'sd40168;
  localparam int                   RATE_LIM    = 17872;
  localparam int                   QUAT_LIM    = 16384;
  localparam int                   SQRT_STEPS  = 16;

  // arctangent of 2^-i, Q30, truncated
  function automatic logic signed [VW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [VW-1:0] r;
    unique case (idx)
      5'd0:    r = 36'sd843314856;
      5'd1:    r = 36'sd497837829;
      5'd2:    r = 36'sd263043836;
      5'd3:    r = 36'sd133525158;
      5'd4:    r = 36'sd67021686;
      5'd5:    r = 36'sd33543515;
      5'd6:    r = 36'sd16775850;
      5'd7:    r = 36'sd8388437;
      5'd8:    r = 36'sd4194282;
      5'd9:    r = 36'sd2097149;
      5'd10:   r = 36'sd1048575;
      5'd11:   r = 36'sd524287;
      5'd12:   r = 36'sd262143;
      5'd13:   r = 36'sd131071;
      5'd14:   r = 36'sd65535;
      5'd15:   r = 36'sd32767;
      5'd16:   r = 36'sd16383;
      5'd17:   r = 36'sd8191;
      5'd18:   r = 36'sd4095;
      5'd19:   r = 36'sd2047;
      5'd20:   r = 36'sd1023;
      5'd21:   r = 36'sd511;
      5'd22:   r = 36'sd255;
      5'd23:   r = 36'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round half up, then arithmetic shift right
  function automatic logic signed [PW-1:0] round_prod(input logic signed [PW-1:0] p,
                                                      input int unsigned sh);
    logic signed [PW-1:0] half;
    half = PW'(1) <<< (sh - 1);
    return (p + half) >>> sh;
  endfunction

  function automatic logic signed [VW-1:0] round_val(input logic signed [VW-1:0] v,
                                                     input int unsigned sh);
    logic signed [VW-1:0] half;
    half = VW'(1) <<< (sh - 1);
    return (v + half) >>> sh;
  endfunction

  // symmetric saturation to +-lim
  function automatic logic signed [15:0] sat16(input logic signed [VW-1:0] v,
                                               input int lim);
    logic signed [VW-1:0] l;
    logic signed [VW-1:0] r;
    l = VW'(lim);
    if (v > l) r = l;
    else if (v < -l) r = -l;
    else r = v;
    return 16'(r);
  endfunction

endpackage

FILE: rtl/imu_complementary_attitude_filter_core.sv
// ----------------------------------------------------------------------------
// IMU complementary attitude filter
// Scales one IMU word, blends gyro and accelerometer tilt, integrates yaw and
// converts the Euler angles to a Q1.14 quaternion.
// ----------------------------------------------------------------------------
// One word is processed at a time: in_ready comes back at the same edge that
// loads the result into the output register. The work is done by one shared
// 34x34 multiplier, one shift-add CORDIC stage run CORDIC_STEPS times for each
// of two atan2 and three sin/cos passes, and a 16-step bit-pair square root. A
// waiting result never blocks acceptance of the next word; it only delays the
// final load if still untaken.
`include "imu_complementary_attitude_filter_core_defines.svh"

module imu_complementary_attitude_filter_core #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  icaf_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output icaf_pkg::out_word_t  out_data,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);

  localparam int MW = icaf_pkg::MW;
  localparam int PW = icaf_pkg::PW;
  localparam int VW = icaf_pkg::VW;
  localparam int AW = ANGLE_FRAC_BITS + 3;
  localparam int SH = 30 - ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] ANG_MAX = AW'(13) <<< (ANGLE_FRAC_BITS - 2);

  typedef enum logic [4:0] {
    S_IDLE, S_RATE, S_SQ0, S_SQ1, S_SQ2, S_SQRT, S_CINIT, S_CITER,
    S_GM1, S_GM2, S_GSUM, S_GB1, S_GB2, S_GB3, S_GSTORE,
    S_TMUL, S_QMUL, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    P_ROLL_ATAN, P_PITCH_ATAN, P_ROLL_SC, P_PITCH_SC, P_YAW_SC
  } pass_t;

  typedef enum logic [1:0] {AX_ROLL, AX_PITCH, AX_YAW} axis_t;

  state_t state;
  pass_t  pass;
  axis_t  axis;
  logic [4:0] cnt;

  logic [15:0]          alpha;
  icaf_pkg::in_word_t   in_r;

  logic signed [AW-1:0] roll_angle, pitch_angle, yaw_angle;
  logic signed [VW-1:0] roll_acc, pitch_acc;

  // shared multiplier
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  // CORDIC stage
  logic signed [MW-1:0] cx, cy;
  logic signed [VW-1:0] cz;
  logic                 vect;
  logic signed [MW-1:0] cx_next, cy_next;
  logic signed [VW-1:0] cz_next;
  logic signed [MW-1:0] ci_x, ci_y;
  logic signed [VW-1:0] ci_z;
  logic                 ci_vect;

  // square root
  logic [31:0] sq_n, root;
  logic [31:0] sq_bit;
  logic [32:0] sq_trial;

  // blend and angle store
  logic signed [VW-1:0] val;
  logic signed [52:0]   bacc;
  logic signed [AW-1:0] angle_sel;
  logic signed [VW-1:0] acc_sel;
  logic signed [VW-1:0] wrapped;
  logic signed [AW-1:0] stored;

  // sin/cos and products
  logic signed [MW-1:0] cos_r, sin_r, cos_p, sin_p, cos_y, sin_y;
  logic signed [MW-1:0] t1, t2, t3, t4;
  logic signed [VW-1:0] qacc;
  logic signed [VW-1:0] r30, r16, qsum;
  logic [4:0]           pj;

  logic signed [15:0] rate_x, rate_y, rate_z, acc_x, acc_y, acc_z;
  logic signed [15:0] qw, qx, qy, qz;

  assign in_ready = (state == S_IDLE);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_RATE: begin
        unique case (cnt)
          5'd0:    mul_a = MW'(in_r.gyro_raw_x);
          5'd1:    mul_a = MW'(in_r.gyro_raw_y);
          5'd2:    mul_a = MW'(in_r.gyro_raw_z);
          5'd3:    mul_a = MW'(in_r.accel_raw_x);
          5'd4:    mul_a = MW'(in_r.accel_raw_y);
          5'd5:    mul_a = MW'(in_r.accel_raw_z);
          default: mul_a = '0;
        endcase
        mul_b = (cnt < 5'd3) ? icaf_pkg::RATE_MUL : icaf_pkg::ACC_MUL;
      end
      S_SQ0: begin
        mul_a = MW'(in_r.accel_raw_y);
        mul_b = MW'(in_r.accel_raw_y);
      end
      S_SQ1: begin
        mul_a = MW'(in_r.accel_raw_z);
        mul_b = MW'(in_r.accel_raw_z);
      end
      S_GM1: begin
        unique case (axis)
          AX_ROLL:  mul_a = MW'(in_r.gyro_raw_x);
          AX_PITCH: mul_a = MW'(in_r.gyro_raw_y);
          default:  mul_a = MW'(in_r.gyro_raw_z);
        endcase
        mul_b = MW'({1'b0, in_r.dt_us});
      end
      S_GM2: begin
        mul_a = MW'(prod);
        mul_b = icaf_pkg::STEP_MUL;
      end
      S_GB1: begin
        mul_a = MW'({1'b0, alpha});
        mul_b = MW'(val);
      end
      S_GB2: begin
        mul_a = MW'(17'h10000 - {1'b0, alpha});
        mul_b = MW'(acc_sel);
      end
      S_TMUL: begin
        unique case (cnt)
          5'd0:    begin mul_a = cos_y; mul_b = cos_r; end
          5'd1:    begin mul_a = sin_y; mul_b = sin_r; end
          5'd2:    begin mul_a = cos_y; mul_b = sin_r; end
          5'd3:    begin mul_a = sin_y; mul_b = cos_r; end
          default: begin mul_a = '0;    mul_b = '0;    end
        endcase
      end
      S_QMUL: begin
        unique case (cnt)
          5'd0:    begin mul_a = t1; mul_b = cos_p; end
          5'd1:    begin mul_a = t2; mul_b = sin_p; end
          5'd2:    begin mul_a = t3; mul_b = cos_p; end
          5'd3:    begin mul_a = t4; mul_b = sin_p; end
          5'd4:    begin mul_a = t1; mul_b = sin_p; end
          5'd5:    begin mul_a = t2; mul_b = cos_p; end
          5'd6:    begin mul_a = t4; mul_b = cos_p; end
          5'd7:    begin mul_a = t3; mul_b = sin_p; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // CORDIC pass setup
  always_comb begin
    logic signed [16:0] vx, vy;
    vx = '0;
    vy = '0;
    ci_x = '0;
    ci_y = '0;
    ci_z = '0;
    ci_vect = 1'b0;
    unique case (pass)
      P_ROLL_ATAN, P_PITCH_ATAN: begin
        if (pass == P_ROLL_ATAN) begin
          vx = 17'(in_r.accel_raw_z);
          vy = 17'(in_r.accel_raw_y);
        end else begin
          vx = 17'(root);
          vy = -(17'(in_r.accel_raw_x));
        end
        ci_vect = 1'b1;
        if (vx < 0) begin
          ci_z = (vy >= 0) ? icaf_pkg::PI_Q30 : -icaf_pkg::PI_Q30;
          vx = -vx;
          vy = -vy;
        end
        ci_x = MW'(vx) <<< 14;
        ci_y = MW'(vy) <<< 14;
      end
      P_ROLL_SC: begin
        ci_x = icaf_pkg::INV_GAIN;
        ci_z = VW'(roll_angle) <<< (SH - 1);
      end
      P_PITCH_SC: begin
        ci_x = icaf_pkg::INV_GAIN;
        ci_z = VW'(pitch_angle) <<< (SH - 1);
      end
      default: begin
        ci_x = icaf_pkg::INV_GAIN;
        ci_z = VW'(yaw_angle) <<< (SH - 1);
      end
    endcase
  end

  // one CORDIC micro-rotation
  always_comb begin
    logic signed [MW-1:0] sx, sy;
    logic signed [VW-1:0] at;
    logic                 dir_neg;
    sx = cx >>> cnt;
    sy = cy >>> cnt;
    at = icaf_pkg::atan_q30(cnt);
    dir_neg = vect ? !cy[MW-1] : cz[VW-1];
    if (dir_neg) begin
      cx_next = cx + sy;
      cy_next = cy - sx;
      cz_next = cz + at;
    end else begin
      cx_next = cx - sy;
      cy_next = cy + sx;
      cz_next = cz - at;
    end
  end

  // square root trial
  assign sq_bit   = 32'(1) << (6'd30 - {cnt, 1'b0});
  assign sq_trial = {1'b0, root} + {1'b0, sq_bit};

  // angle and tilt selection by axis
  always_comb begin
    unique case (axis)
      AX_ROLL:  begin angle_sel = roll_angle;  acc_sel = roll_acc;  end
      AX_PITCH: begin angle_sel = pitch_angle; acc_sel = pitch_acc; end
      default:  begin angle_sel = yaw_angle;   acc_sel = '0;        end
    endcase
  end

  // wrap into +-pi and round to stored precision
  always_comb begin
    if (val > icaf_pkg::PI_Q30) wrapped = val - icaf_pkg::TWO_PI_Q30;
    else if (val < -icaf_pkg::PI_Q30) wrapped = val + icaf_pkg::TWO_PI_Q30;
    else wrapped = val;
    stored = AW'(icaf_pkg::round_val(wrapped, SH));
  end

  // product post-processing
  assign pj   = cnt - 5'd1;
  assign r30  = VW'(icaf_pkg::round_prod(prod, 30));
  assign r16  = VW'(icaf_pkg::round_prod(prod, 16));
  assign qsum = (pj == 5'd3 || pj == 5'd7) ? (qacc - r30) : (qacc + r30);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pass        <= P_ROLL_ATAN;
      axis        <= AX_ROLL;
      cnt         <= '0;
      alpha       <= icaf_pkg::ALPHA_RESET;
      roll_angle  <= '0;
      pitch_angle <= '0;
      yaw_angle   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) alpha <= cfg_wdata;
      // the final load below takes over the handshake while in S_DONE
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_r  <= in_data;
            cnt   <= '0;
            state <= S_RATE;
          end
        end
        // rates and accelerations, one product behind the multiply
        S_RATE: begin
          if (cnt != 5'd0) begin
            unique case (pj)
              5'd0:    rate_x <= icaf_pkg::sat16(r16, icaf_pkg::RATE_LIM);
              5'd1:    rate_y <= icaf_pkg::sat16(r16, icaf_pkg::RATE_LIM);
              5'd2:    rate_z <= icaf_pkg::sat16(r16, icaf_pkg::RATE_LIM);
              5'd3:    acc_x  <= 16'(r16);
              5'd4:    acc_y  <= 16'(r16);
              default: acc_z  <= 16'(r16);
            endcase
          end
          if (cnt == 5'd6) state <= S_SQ0;
          else cnt <= cnt + 5'd1;
        end
        S_SQ0: state <= S_SQ1;
        S_SQ1: begin
          sq_n  <= 32'(prod);
          state <= S_SQ2;
        end
        S_SQ2: begin
          sq_n  <= sq_n + 32'(prod);
          root  <= '0;
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if ({1'b0, sq_n} >= sq_trial) begin
            sq_n <= sq_n - 32'(sq_trial);
            root <= (root >> 1) + sq_bit;
          end else begin
            root <= root >> 1;
          end
          if (cnt == 5'(icaf_pkg::SQRT_STEPS - 1)) begin
            pass  <= P_ROLL_ATAN;
            state <= S_CINIT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_CINIT: begin
          cx    <= ci_x;
          cy    <= ci_y;
          cz    <= ci_z;
          vect  <= ci_vect;
          cnt   <= '0;
          state <= S_CITER;
        end
        S_CITER: begin
          cx <= cx_next;
          cy <= cy_next;
          cz <= cz_next;
          if (cnt == 5'(CORDIC_STEPS - 1)) begin
            unique case (pass)
              P_ROLL_ATAN: begin
                roll_acc <= cz_next;
                pass     <= P_PITCH_ATAN;
                state    <= S_CINIT;
              end
              P_PITCH_ATAN: begin
                pitch_acc <= cz_next;
                axis      <= AX_ROLL;
                state     <= S_GM1;
              end
              P_ROLL_SC: begin
                cos_r <= cx_next;
                sin_r <= cy_next;
                pass  <= P_PITCH_SC;
                state <= S_CINIT;
              end
              P_PITCH_SC: begin
                cos_p <= cx_next;
                sin_p <= cy_next;
                pass  <= P_YAW_SC;
                state <= S_CINIT;
              end
              default: begin
                cos_y <= cx_next;
                sin_y <= cy_next;
                cnt   <= '0;
                state <= S_TMUL;
              end
            endcase
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        // gyro increment per axis, blend for roll and pitch
        S_GM1: state <= S_GM2;
        S_GM2: state <= S_GSUM;
        S_GSUM: begin
          val   <= (VW'(angle_sel) <<< SH) + VW'(icaf_pkg::round_prod(prod, 32));
          state <= (axis == AX_YAW) ? S_GSTORE : S_GB1;
        end
        S_GB1: state <= S_GB2;
        S_GB2: begin
          bacc  <= 53'(prod);
          state <= S_GB3;
        end
        S_GB3: begin
          val   <= VW'(icaf_pkg::round_prod(PW'(bacc) + prod, 16));
          state <= S_GSTORE;
        end
        S_GSTORE: begin
          unique case (axis)
            AX_ROLL: begin
              roll_angle <= stored;
              axis       <= AX_PITCH;
              state      <= S_GM1;
            end
            AX_PITCH: begin
              pitch_angle <= stored;
              axis        <= AX_YAW;
              state       <= S_GM1;
            end
            default: begin
              yaw_angle <= stored;
              pass      <= P_ROLL_SC;
              state     <= S_CINIT;
            end
          endcase
        end
        // yaw by roll cross terms
        S_TMUL: begin
          if (cnt != 5'd0) begin
            unique case (pj)
              5'd0:    t1 <= MW'(r30);
              5'd1:    t2 <= MW'(r30);
              5'd2:    t3 <= MW'(r30);
              default: t4 <= MW'(r30);
            endcase
          end
          if (cnt == 5'd4) begin
            cnt   <= '0;
            state <= S_QMUL;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        // quaternion terms, pairs summed or differenced
        S_QMUL: begin
          if (cnt != 5'd0) begin
            if (!pj[0]) begin
              qacc <= r30;
            end else begin
              unique case (pj[2:1])
                2'd0:    qw <= icaf_pkg::sat16(icaf_pkg::round_val(qsum, 16),
                                               icaf_pkg::QUAT_LIM);
                2'd1:    qx <= icaf_pkg::sat16(icaf_pkg::round_val(qsum, 16),
                                               icaf_pkg::QUAT_LIM);
                2'd2:    qy <= icaf_pkg::sat16(icaf_pkg::round_val(qsum, 16),
                                               icaf_pkg::QUAT_LIM);
                default: qz <= icaf_pkg::sat16(icaf_pkg::round_val(qsum, 16),
                                               icaf_pkg::QUAT_LIM);
              endcase
            end
          end
          if (cnt == 5'd8) state <= S_DONE;
          else cnt <= cnt + 5'd1;
        end
        // load output register once it is free
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.quat_w  <= qw;
            out_data.quat_x  <= qx;
            out_data.quat_y  <= qy;
            out_data.quat_z  <= qz;
            out_data.rate_x  <= rate_x;
            out_data.rate_y  <= rate_y;
            out_data.rate_z  <= rate_z;
            out_data.accel_x <= acc_x;
            out_data.accel_y <= acc_y;
            out_data.accel_z <= acc_z;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `ICAF_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready after accept")
  `ICAF_ASSERT(a_cordic_count, (state == S_CITER) |-> (cnt < 5'(CORDIC_STEPS)), "CORDIC overrun")
  `ICAF_ASSERT(a_done_loads, (state == S_DONE && !out_valid) |=> out_valid, "result not loaded")
  `ICAF_ASSERT(a_roll_range, (state == S_DONE) |-> (roll_angle <= ANG_MAX && roll_angle >= -ANG_MAX), "roll unwrapped")

endmodule
